>>> src/wcv_pkg.sv
// Shared types and constants for the three-axis running covariance block.
`default_nettype none
package wcv_pkg;

    // Width of the running square and cross sums.
    localparam int SUM_BITS = 64;

    // Command to the shared bit-serial unit.
    typedef struct packed {
        logic start;    // load operands and begin
        logic div;      // 1: divide, 0: multiply
    } t_cmd;

endpackage
`default_nettype wire

>>> src/wcv_iter.sv
// Shared bit-serial unit: restoring divide or shift-add multiply on magnitudes.
`default_nettype none
module wcv_iter #(
    parameter int NUM_BITS = 64,
    parameter int DEN_BITS = 24,
    parameter int MUL_BITS = 33
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wcv_pkg::t_cmd              i_cmd,
    input  wire  [NUM_BITS-1:0]        i_num,
    input  wire  [DEN_BITS-1:0]        i_den,
    input  wire  [MUL_BITS-1:0]        i_mul_a,
    input  wire  [MUL_BITS-1:0]        i_mul_b,
    output logic                       o_done,
    output logic [NUM_BITS-1:0]        o_quot,
    output logic [2*MUL_BITS-1:0]      o_prod
);
    localparam int STEPS_MAX = (NUM_BITS > MUL_BITS) ? NUM_BITS : MUL_BITS;
    localparam int CW = $clog2(STEPS_MAX + 1);

    logic                  r_run;
    logic                  r_div;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [DEN_BITS-1:0]   r_rem;
    logic [DEN_BITS-1:0]   r_den;
    logic [NUM_BITS-1:0]   r_sh;
    logic [MUL_BITS-1:0]   r_mcand;
    logic [2*MUL_BITS-1:0] r_prod;

    logic [DEN_BITS:0]     w_trial;
    logic [DEN_BITS:0]     w_diff;
    logic                  w_ge;
    logic [MUL_BITS:0]     w_psum;
    logic                  w_last;

    always_comb begin
        w_trial = {r_rem, r_sh[NUM_BITS-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
        w_psum  = {1'b0, r_prod[2*MUL_BITS-1:MUL_BITS]}
                + (r_prod[0] ? {1'b0, r_mcand} : '0);
        w_last  = r_div ? (r_cnt == CW'(NUM_BITS - 1)) : (r_cnt == CW'(MUL_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_div  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_run   <= 1'b1;
                r_div   <= i_cmd.div;
                r_cnt   <= '0;
                r_rem   <= '0;
                r_den   <= i_den;
                r_sh    <= i_num;
                r_mcand <= i_mul_a;
                r_prod  <= {{MUL_BITS{1'b0}}, i_mul_b};
            end else if (r_run) begin
                if (r_div) begin
                    r_rem <= w_ge ? w_diff[DEN_BITS-1:0] : w_trial[DEN_BITS-1:0];
                    r_sh  <= {r_sh[NUM_BITS-2:0], w_ge};
                end else begin
                    r_prod <= {w_psum, r_prod[MUL_BITS-1:1]};
                end
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh;
    assign o_prod = r_prod;

endmodule
`default_nettype wire

>>> src/running_covariance_3axis_core.sv
// Top level: running mean, variance and covariance of a three-axis sample stream.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------
//  in      | i_valid / o_ready  | i_sample_x, i_sample_y, i_sample_z
//  out     | o_valid / i_ready  | o_sample_count, o_mean_*, o_variance_*, o_covariance_*
//
// One word in gives one word out. All arithmetic runs on one bit-serial unit:
// three mean divides by the count, six deviation products and six sum divides
// by count-1, each followed by a handoff before the next operation starts.
// The very first word after reset skips all of that and goes straight to output.
// o_ready is high only while idle; a finished word is held until i_ready takes it.
// Reset (synchronous, active low) clears the count, means and sums.
`default_nettype none
module running_covariance_3axis_core #(
    parameter int COUNT_BITS    = 24,
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire                                          i_clk,
    input  wire                                          i_rst_n,
    input  wire                                          i_valid,
    output logic                                         o_ready,
    input  wire  signed [SAMPLE_BITS-1:0]                i_sample_x,
    input  wire  signed [SAMPLE_BITS-1:0]                i_sample_y,
    input  wire  signed [SAMPLE_BITS-1:0]                i_sample_z,
    output logic                                         o_valid,
    input  wire                                          i_ready,
    output logic        [COUNT_BITS-1:0]                 o_sample_count,
    output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0]  o_mean_x,
    output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0]  o_mean_y,
    output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0]  o_mean_z,
    output logic        [2*SAMPLE_BITS+FRACTION_BITS-3:0] o_variance_x,
    output logic        [2*SAMPLE_BITS+FRACTION_BITS-3:0] o_variance_y,
    output logic        [2*SAMPLE_BITS+FRACTION_BITS-3:0] o_variance_z,
    output logic signed [2*SAMPLE_BITS+FRACTION_BITS-2:0] o_covariance_xy,
    output logic signed [2*SAMPLE_BITS+FRACTION_BITS-2:0] o_covariance_yz,
    output logic signed [2*SAMPLE_BITS+FRACTION_BITS-2:0] o_covariance_zx
);
    localparam int MB  = SAMPLE_BITS + FRACTION_BITS;       // mean width
    localparam int AW  = MB + 1;                             // deviation width
    localparam int VB  = 2 * SAMPLE_BITS + FRACTION_BITS - 2;
    localparam int CB  = VB + 1;
    localparam int SB  = wcv_pkg::SUM_BITS;
    localparam int PW  = 2 * AW;
    localparam int SHW = PW - FRACTION_BITS;
    localparam int EW  = (SHW > SB) ? SHW : SB;
    localparam int QX  = ((CB > SB) ? CB : SB) + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MDIV = 3'd1;   // mean update divides
    localparam logic [2:0] S_MUL  = 3'd2;   // deviation products
    localparam logic [2:0] S_ODIV = 3'd3;   // output divides
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [SB-1:0] SUM_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] SUM_MIN = {1'b1, {(SB-1){1'b0}}};
    localparam logic [QX-1:0] VLIM    = (QX'(1) << VB) - QX'(1);
    localparam logic [QX-1:0] CHI     = (QX'(1) << (CB - 1)) - QX'(1);

    logic [2:0]                r_state;
    logic [2:0]                r_idx;
    logic                      r_go;
    logic [COUNT_BITS-1:0]     r_count;
    logic signed [MB-1:0]      r_xf   [3];
    logic signed [MB-1:0]      r_mean [3];
    logic signed [AW-1:0]      r_a    [3];
    logic signed [SB-1:0]      r_sq   [3];
    logic signed [SB-1:0]      r_cr   [3];
    logic [VB-1:0]             r_var  [3];
    logic [CB-1:0]             r_cov  [3];

    logic signed [AW-1:0]      w_d [3];
    logic [1:0]                w_ax;
    logic [1:0]                w_jx;
    wcv_pkg::t_cmd             w_cmd;
    logic [SB-1:0]             w_num;
    logic [COUNT_BITS-1:0]     w_den;
    logic [AW-1:0]             w_ma;
    logic [AW-1:0]             w_mb;
    logic                      w_done;
    logic [SB-1:0]             w_quot;
    logic [PW-1:0]             w_prod;
    logic signed [SB-1:0]      w_sum_sel;
    logic signed [AW-1:0]      w_qm;
    logic [MB-1:0]             w_mean_new;
    logic [EW-1:0]             w_pext;
    logic [SB-1:0]             w_pmag;
    logic [SB-1:0]             w_term;
    logic                      w_pneg;
    logic [SB:0]               w_acc;
    logic [SB-1:0]             w_acc_sat;
    logic [QX-1:0]             w_qx;
    logic [QX-1:0]             w_qneg;
    logic [VB-1:0]             w_var;
    logic [CB-1:0]             w_cov;
    logic [SAMPLE_BITS-1:0]    w_smp [3];

    function automatic logic [AW-1:0] f_abs(input logic [AW-1:0] v);
        f_abs = v[AW-1] ? (AW'(0) - v) : v;
    endfunction

    function automatic logic [1:0] f_next(input logic [1:0] k);
        case (k)
            2'd0:    f_next = 2'd1;
            2'd1:    f_next = 2'd2;
            default: f_next = 2'd0;
        endcase
    endfunction

    assign w_smp[0] = i_sample_x;
    assign w_smp[1] = i_sample_y;
    assign w_smp[2] = i_sample_z;

    // deviation of each lane from its current mean: a before the update, b after
    for (genvar k = 0; k < 3; k++) begin : g_lane
        assign w_d[k] = AW'(r_xf[k]) - AW'(r_mean[k]);
    end

    always_comb begin
        w_ax = (r_idx < 3'd3) ? r_idx[1:0] : 2'(r_idx - 3'd3);
        w_jx = (r_idx < 3'd3) ? w_ax : f_next(w_ax);
        w_sum_sel = (r_idx < 3'd3) ? r_sq[w_ax] : r_cr[w_ax];

        w_cmd.start = ((r_state == S_MDIV) || (r_state == S_MUL) || (r_state == S_ODIV))
                      && !r_go;
        w_cmd.div   = (r_state != S_MUL);

        if (r_state == S_MDIV) begin
            w_num = SB'(f_abs(w_d[w_ax]));
            w_den = r_count;
        end else begin
            w_num = w_sum_sel[SB-1] ? (SB'(0) - w_sum_sel) : w_sum_sel;
            w_den = r_count - 1'b1;
        end
        w_ma = f_abs(r_a[w_ax]);
        w_mb = f_abs(w_d[w_jx]);

        // mean += a / n, truncated toward zero
        w_qm       = w_d[w_ax][AW-1] ? (AW'(0) - AW'(w_quot)) : AW'(w_quot);
        w_mean_new = MB'(AW'(r_mean[w_ax]) + w_qm);

        // product shifted down by the fraction, magnitude capped, then signed
        w_pext = EW'(w_prod[PW-1:FRACTION_BITS]);
        w_pmag = (|w_pext[EW-1:SB-1]) ? SUM_MAX : w_pext[SB-1:0];
        w_pneg = r_a[w_ax][AW-1] ^ w_d[w_jx][AW-1];
        w_term = w_pneg ? (SB'(0) - w_pmag) : w_pmag;

        // saturating accumulate
        w_acc = {w_sum_sel[SB-1], w_sum_sel} + {w_term[SB-1], w_term};
        if (w_acc[SB] != w_acc[SB-1]) begin
            w_acc_sat = w_acc[SB] ? SUM_MIN : SUM_MAX;
        end else begin
            w_acc_sat = w_acc[SB-1:0];
        end

        // output quotient clamps
        w_qx   = QX'(w_quot);
        w_qneg = QX'(0) - w_qx;
        if (w_sum_sel[SB-1]) begin
            w_var = '0;
        end else begin
            w_var = (w_qx > VLIM) ? VLIM[VB-1:0] : w_qx[VB-1:0];
        end
        if (w_sum_sel[SB-1]) begin
            w_cov = (w_qx > (CHI + QX'(1))) ? {1'b1, {(CB-1){1'b0}}} : w_qneg[CB-1:0];
        end else begin
            w_cov = (w_qx > CHI) ? CHI[CB-1:0] : w_qx[CB-1:0];
        end
    end

    wcv_iter #(
        .NUM_BITS (SB),
        .DEN_BITS (COUNT_BITS),
        .MUL_BITS (AW)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_mul_a (w_ma),
        .i_mul_b (w_mb),
        .o_done  (w_done),
        .o_quot  (w_quot),
        .o_prod  (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_go    <= 1'b0;
            r_count <= '0;
            for (int k = 0; k < 3; k++) begin
                r_mean[k] <= '0;
                r_sq[k]   <= '0;
                r_cr[k]   <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        for (int k = 0; k < 3; k++) begin
                            r_xf[k] <= {w_smp[k], {FRACTION_BITS{1'b0}}};
                        end
                        if (r_count != {COUNT_BITS{1'b1}}) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (r_count == '0) begin
                            // first word: means take the sample, spreads are zero
                            for (int k = 0; k < 3; k++) begin
                                r_mean[k] <= {w_smp[k], {FRACTION_BITS{1'b0}}};
                                r_sq[k]   <= '0;
                                r_cr[k]   <= '0;
                                r_var[k]  <= '0;
                                r_cov[k]  <= '0;
                            end
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_MDIV;
                        end
                        r_idx <= '0;
                        r_go  <= 1'b0;
                    end
                end
                S_MDIV: begin
                    if (!r_go) begin
                        r_go <= 1'b1;
                    end else if (w_done) begin
                        r_go         <= 1'b0;
                        r_a[w_ax]    <= w_d[w_ax];
                        r_mean[w_ax] <= w_mean_new;
                        if (r_idx == 3'd2) begin
                            r_idx   <= '0;
                            r_state <= S_MUL;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_MUL: begin
                    if (!r_go) begin
                        r_go <= 1'b1;
                    end else if (w_done) begin
                        r_go <= 1'b0;
                        if (r_idx < 3'd3) begin
                            r_sq[w_ax] <= w_acc_sat;
                        end else begin
                            r_cr[w_ax] <= w_acc_sat;
                        end
                        if (r_idx == 3'd5) begin
                            r_idx   <= '0;
                            r_state <= S_ODIV;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_ODIV: begin
                    if (!r_go) begin
                        r_go <= 1'b1;
                    end else if (w_done) begin
                        r_go <= 1'b0;
                        if (r_idx < 3'd3) begin
                            r_var[w_ax] <= w_var;
                        end else begin
                            r_cov[w_ax] <= w_cov;
                        end
                        if (r_idx == 3'd5) begin
                            r_idx   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_sample_count  = r_count;
    assign o_mean_x        = r_mean[0];
    assign o_mean_y        = r_mean[1];
    assign o_mean_z        = r_mean[2];
    assign o_variance_x    = r_var[0];
    assign o_variance_y    = r_var[1];
    assign o_variance_z    = r_var[2];
    assign o_covariance_xy = r_cov[0];
    assign o_covariance_yz = r_cov[1];
    assign o_covariance_zx = r_cov[2];

    // never open for a new word while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input open while result pending");

    // a taken result is not shown twice
    a_single_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> !o_valid)
        else $error("result repeated");

    // an accepted word always leaves a nonzero count
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (o_sample_count != '0))
        else $error("count not advanced");

    // a single sample has no spread
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_sample_count == COUNT_BITS'(1))) |->
        (o_variance_x == '0 && o_variance_y == '0 && o_variance_z == '0 &&
         o_covariance_xy == '0 && o_covariance_yz == '0 && o_covariance_zx == '0))
        else $error("nonzero spread on first sample");

endmodule
`default_nettype wire

>>> tb/tb_running_covariance_3axis_core.sv
// Testbench for running_covariance_3axis_core: random three-axis words, scoreboard check.
`default_nettype none
module tb_running_covariance_3axis_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      COUNT_W = 24;
    localparam int      SMP_W   = 16;
    localparam int      FRAC_W  = 16;
    localparam int      MEAN_W  = SMP_W + FRAC_W;
    localparam int      VAR_W   = 2 * SMP_W + FRAC_W - 2;
    localparam int      COV_W   = VAR_W + 1;
    localparam longint  COUNT_MAX = (64'd1 << COUNT_W) - 1;
    localparam longint  SUM_MAX   = 64'sh7fff_ffff_ffff_ffff;
    localparam longint  SUM_MIN   = 64'sh8000_0000_0000_0000;
    localparam longint  VAR_MAX   = (64'sd1 << VAR_W) - 1;
    localparam longint  COV_MAX   = (64'sd1 << (COV_W - 1)) - 1;
    localparam longint  COV_MIN   = -COV_MAX - 1;
    localparam int      N_WORDS   = 1200;

    // One output word, fields at port widths.
    typedef struct {
        logic        [COUNT_W-1:0] cnt;
        logic signed [MEAN_W-1:0]  mean[3];
        logic        [VAR_W-1:0]   vari[3];
        logic signed [COV_W-1:0]   cov[3];
    } t_stats_word;

    // Holds the running statistics model and the words still owed by the block.
    class cov_scoreboard;
        t_stats_word owed_q[$];
        int          errors;
        longint      cnt;
        longint      mean[3];
        longint      sq_sum[3];
        longint      cross_sum[3];

        function new();
            errors = 0;
            cnt    = 0;
            for (int i = 0; i < 3; i++) begin
                mean[i]      = 0;
                sq_sum[i]    = 0;
                cross_sum[i] = 0;
            end
        endfunction

        // (a*b) >> FRAC_W on magnitudes, sign reapplied, capped at int64 max.
        function longint scaled_product(longint a, longint b);
            logic [63:0]  ua, ub, mag;
            logic [127:0] p;
            bit           neg;
            neg = (a < 0) != (b < 0);
            ua  = (a < 0) ? -a : a;
            ub  = (b < 0) ? -b : b;
            p   = {64'd0, ua} * {64'd0, ub};
            if (p[127:64+FRAC_W] != 0)
                mag = SUM_MAX;
            else
                mag = p[64+FRAC_W-1:FRAC_W];
            if (mag > SUM_MAX)
                mag = SUM_MAX;
            return neg ? -longint'(mag) : longint'(mag);
        endfunction

        function longint sat_add(longint s, longint t);
            if (t > 0 && s > SUM_MAX - t)
                return SUM_MAX;
            if (t < 0 && s < SUM_MIN - t)
                return SUM_MIN;
            return s + t;
        endfunction

        function void note_sample(logic signed [SMP_W-1:0] x, y, z);
            longint      xf[3], a[3], b[3], q;
            t_stats_word w;
            xf[0] = longint'(x) <<< FRAC_W;
            xf[1] = longint'(y) <<< FRAC_W;
            xf[2] = longint'(z) <<< FRAC_W;
            if (cnt < COUNT_MAX)
                cnt++;
            if (cnt == 1) begin
                // first word seeds the means, sums start clean
                for (int i = 0; i < 3; i++) begin
                    mean[i]      = xf[i];
                    sq_sum[i]    = 0;
                    cross_sum[i] = 0;
                end
            end else begin
                for (int i = 0; i < 3; i++) begin
                    a[i]    = xf[i] - mean[i];
                    mean[i] = mean[i] + a[i] / cnt;
                    b[i]    = xf[i] - mean[i];
                end
                for (int i = 0; i < 3; i++) begin
                    sq_sum[i]    = sat_add(sq_sum[i], scaled_product(a[i], b[i]));
                    cross_sum[i] = sat_add(cross_sum[i], scaled_product(a[i], b[(i+1)%3]));
                end
            end
            w.cnt = cnt[COUNT_W-1:0];
            for (int i = 0; i < 3; i++) begin
                w.mean[i] = mean[i][MEAN_W-1:0];
                w.vari[i] = '0;
                w.cov[i]  = '0;
                if (cnt >= 2) begin
                    q = sq_sum[i] / (cnt - 1);
                    if (q < 0)
                        q = 0;
                    if (q > VAR_MAX)
                        q = VAR_MAX;
                    w.vari[i] = q[VAR_W-1:0];
                    q = cross_sum[i] / (cnt - 1);
                    if (q > COV_MAX)
                        q = COV_MAX;
                    if (q < COV_MIN)
                        q = COV_MIN;
                    w.cov[i] = q[COV_W-1:0];
                end
            end
            owed_q.push_back(w);
        endfunction

        function void field_cmp(string name, logic [63:0] e, logic [63:0] g, ref bit bad);
            if (e !== g) begin
                bad = 1;
                if (errors < 10)
                    $display("mismatch %s: expected %h got %h", name, e, g);
            end
        endfunction

        function void check_word(t_stats_word g);
            t_stats_word e;
            bit          bad;
            string       ax;
            bad = 0;
            if (owed_q.size() == 0) begin
                if (errors < 10)
                    $display("unexpected output word, count %0d", g.cnt);
                errors++;
                return;
            end
            e = owed_q.pop_front();
            field_cmp("sample_count", 64'(e.cnt), 64'(g.cnt), bad);
            for (int i = 0; i < 3; i++) begin
                ax = (i == 0) ? "x" : (i == 1) ? "y" : "z";
                field_cmp({"mean_", ax}, 64'(unsigned'(e.mean[i])),
                          64'(unsigned'(g.mean[i])), bad);
                field_cmp({"variance_", ax}, 64'(e.vari[i]), 64'(g.vari[i]), bad);
                field_cmp({"covariance_", ax}, 64'(unsigned'(e.cov[i])),
                          64'(unsigned'(g.cov[i])), bad);
            end
            if (bad)
                errors++;
        endfunction
    endclass

    logic                      i_clk = 0;
    logic                      i_rst_n = 0;
    logic                      i_valid = 0;
    logic                      i_ready = 0;
    logic signed [SMP_W-1:0]   i_sample_x = '0;
    logic signed [SMP_W-1:0]   i_sample_y = '0;
    logic signed [SMP_W-1:0]   i_sample_z = '0;
    wire                       o_ready;
    wire                       o_valid;
    wire        [COUNT_W-1:0]  o_sample_count;
    wire signed [MEAN_W-1:0]   o_mean_x, o_mean_y, o_mean_z;
    wire        [VAR_W-1:0]    o_variance_x, o_variance_y, o_variance_z;
    wire signed [COV_W-1:0]    o_covariance_xy, o_covariance_yz, o_covariance_zx;

    cov_scoreboard sb = new();

    always #6 i_clk = ~i_clk;

    running_covariance_3axis_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample_x      (i_sample_x),
        .i_sample_y      (i_sample_y),
        .i_sample_z      (i_sample_z),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sample_count  (o_sample_count),
        .o_mean_x        (o_mean_x),
        .o_mean_y        (o_mean_y),
        .o_mean_z        (o_mean_z),
        .o_variance_x    (o_variance_x),
        .o_variance_y    (o_variance_y),
        .o_variance_z    (o_variance_z),
        .o_covariance_xy (o_covariance_xy),
        .o_covariance_yz (o_covariance_yz),
        .o_covariance_zx (o_covariance_zx)
    );

    // Receiver stall pattern: phases of always-ready, coin-flip, and long stalls.
    int rx_phase_left = 0;
    int rx_mode = 0;
    int rx_hold = 0;
    always @(posedge i_clk) begin
        if (rx_phase_left == 0) begin
            rx_mode       = $urandom_range(0, 2);
            rx_phase_left = $urandom_range(200, 3000);
        end else begin
            rx_phase_left--;
        end
        case (rx_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            default: begin
                // one ready cycle, then held low until the random hold count runs out
                if (rx_hold == 0) begin
                    rx_hold = $urandom_range(1, 40);
                    i_ready <= 1'b1;
                end else begin
                    rx_hold--;
                    i_ready <= 1'b0;
                end
            end
        endcase
    end

    // Output monitor: words are taken on valid & ready at the edge.
    always @(posedge i_clk) begin
        t_stats_word g;
        if (i_rst_n && o_valid && i_ready) begin
            g.cnt     = o_sample_count;
            g.mean[0] = o_mean_x;
            g.mean[1] = o_mean_y;
            g.mean[2] = o_mean_z;
            g.vari[0] = o_variance_x;
            g.vari[1] = o_variance_y;
            g.vari[2] = o_variance_z;
            g.cov[0]  = o_covariance_xy;
            g.cov[1]  = o_covariance_yz;
            g.cov[2]  = o_covariance_zx;
            sb.check_word(g);
        end
    end

    // Present one word and hold it until accepted; valid stays high on return.
    task automatic send_sample(logic signed [SMP_W-1:0] x, y, z);
        i_valid    <= 1'b1;
        i_sample_x <= x;
        i_sample_y <= y;
        i_sample_z <= z;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(x, y, z);
    endtask

    task automatic idle_gap(int cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [SMP_W-1:0] pick_value(int mode,
                                                           logic signed [SMP_W-1:0] bias);
        logic [31:0] r;
        r = $urandom;
        case (mode)
            0: return r[SMP_W-1:0];
            1: return SMP_W'(bias + $signed(r[4:0]) - 16);   // tight cluster, small variance
            default: return r[0] ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    initial begin
        #80_000_000;
        $display("FAIL running_covariance_3axis_core");
        $finish;
    end

    initial begin
        logic signed [SMP_W-1:0] dx[16], dy[16], dz[16];
        logic signed [SMP_W-1:0] bias;
        int burst, mode;
        // Directed: first word, extremes, sign flips, constants and opposing axes.
        dx = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 0, -1, 1, 16'sh7fff,
               16'sh8000, 16'sh5555, 16'shaaaa, 100, 100, 100, -300, 16'sh7fff};
        dy = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 0, -1, -1, 16'sh7fff,
               16'sh8000, 16'shaaaa, 16'sh5555, 100, 100, 100, 300, 16'sh8000};
        dz = '{0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff, -1, 16'sh8000, 16'sh7fff,
               16'sh8000, 16'sh00ff, 16'shff00, 100, 100, 100, 0, 16'sh7fff};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < 16; i++) begin
            send_sample(dx[i], dy[i], dz[i]);
            if (i % 5 == 4)
                idle_gap($urandom_range(1, 7));
        end
        // Random part in bursts; a mode per burst shapes the sample statistics.
        for (int n = 0; n < N_WORDS; ) begin
            burst = $urandom_range(1, 20);
            mode  = $urandom_range(0, 9);
            mode  = (mode < 7) ? 0 : (mode < 9) ? 1 : 2;
            bias  = SMP_W'($urandom);
            for (int k = 0; k < burst && n < N_WORDS; k++, n++)
                send_sample(pick_value(mode, bias), pick_value(mode, bias),
                            pick_value(mode, bias));
            if (n >= N_WORDS / 2 && n - burst < N_WORDS / 2) begin
                // drain everything once mid-run
                i_valid <= 1'b0;
                while (sb.owed_q.size() != 0) @(posedge i_clk);
            end else if ($urandom_range(0, 3) != 0) begin
                idle_gap($urandom_range(0, 40));
            end
        end
        i_valid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS running_covariance_3axis_core");
        else
            $display("FAIL running_covariance_3axis_core");
        $finish;
    end
endmodule
`default_nettype wire
